/* hdl/inactivity_mood_controller_macros.svh */
// Assertion macros shared by the inactivity mood controller files.
`ifndef INACTIVITY_MOOD_CONTROLLER_MACROS_SVH
`define INACTIVITY_MOOD_CONTROLLER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define IMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define IMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/imc_pkg.sv */
// Types, constants and the brightness table of the inactivity mood controller.
`timescale 1ns / 1ps

package imc_pkg;

  typedef enum logic [1:0] {
    LVL_AWAKE   = 2'd0,
    LVL_AMBIENT = 2'd1,
    LVL_WHISPER = 2'd2,
    LVL_DREAM   = 2'd3
  } level_t;

  localparam logic [1:0] REG_AMBIENT_AFTER = 2'd0;
  localparam logic [1:0] REG_WHISPER_AFTER = 2'd1;
  localparam logic [1:0] REG_DREAM_AFTER   = 2'd2;
  localparam logic [1:0] REG_SLEEP_DELAY   = 2'd3;

  typedef struct packed {
    logic [31:0] ambient_after_ms;
    logic [31:0] whisper_after_ms;
    logic [31:0] dream_after_ms;
    logic [31:0] sleep_delay_ms;
  } cfg_t;

  typedef struct packed {
    level_t      level;
    logic [31:0] still_since;
    logic [31:0] last_change_time;
  } state_t;

  typedef struct packed {
    level_t     level;
    logic [6:0] brightness;
    logic       clock_shown;
    logic       voice_ready;
    logic       level_changed;
    logic       sleep_due;
  } result_t;

  function automatic logic [6:0] brightness_of(level_t lv);
    logic [6:0] b;
    case (lv)
      LVL_AWAKE:   b = 7'd100;
      LVL_AMBIENT: b = 7'd48;
      LVL_WHISPER: b = 7'd22;
      LVL_DREAM:   b = 7'd8;
      default:     b = 7'd100;
    endcase
    return b;
  endfunction

endpackage

/* hdl/imc_eval.sv */
// Per-item level decision: next state and result from the current state.
`timescale 1ns / 1ps

module imc_eval (
  input  imc_pkg::state_t  state,
  input  imc_pkg::cfg_t    cfg,
  input  logic             cmd,
  input  logic [31:0]      now_ms,
  input  logic             screen_down,
  input  logic             moving,
  input  logic             user_active,
  output imc_pkg::state_t  state_next,
  output imc_pkg::result_t result
);

  logic [31:0]     idle_ms;
  logic [31:0]     since_change_ms;
  imc_pkg::level_t timed_level;
  imc_pkg::level_t lv;
  logic            changed;
  logic            delay_done;

  assign idle_ms         = now_ms - state.still_since;
  assign since_change_ms = now_ms - state.last_change_time;

  always_comb begin
    if (idle_ms >= cfg.dream_after_ms) begin
      timed_level = imc_pkg::LVL_DREAM;
    end else if (idle_ms >= cfg.whisper_after_ms) begin
      timed_level = imc_pkg::LVL_WHISPER;
    end else if (idle_ms >= cfg.ambient_after_ms) begin
      timed_level = imc_pkg::LVL_AMBIENT;
    end else begin
      timed_level = imc_pkg::LVL_AWAKE;
    end
  end

  always_comb begin
    state_next = state;
    if (cmd) begin
      lv                     = imc_pkg::LVL_AWAKE;
      state_next.still_since = now_ms;
    end else if (screen_down) begin
      lv                     = imc_pkg::LVL_DREAM;
      state_next.still_since = now_ms;
    end else if (moving || user_active) begin
      lv                     = imc_pkg::LVL_AWAKE;
      state_next.still_since = now_ms;
    end else begin
      lv = timed_level;
    end
    changed          = (lv != state.level);
    state_next.level = lv;
    if (changed || cmd) begin
      state_next.last_change_time = now_ms;
    end
  end

  // a fresh change means zero time in the new level
  assign delay_done = changed ? (cfg.sleep_delay_ms == 32'd0)
                              : (since_change_ms >= cfg.sleep_delay_ms);

  always_comb begin
    result.level         = lv;
    result.brightness    = imc_pkg::brightness_of(lv);
    result.clock_shown   = (lv != imc_pkg::LVL_AWAKE);
    result.voice_ready   = (lv == imc_pkg::LVL_AWAKE) || (lv == imc_pkg::LVL_AMBIENT);
    result.level_changed = changed;
    result.sleep_due     = (lv == imc_pkg::LVL_DREAM) && delay_done;
  end

endmodule

/* hdl/imc_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`include "inactivity_mood_controller_macros.svh"

module imc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  imc_pkg::result_t load_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output imc_pkg::result_t out_data
);

  logic             skid_valid;
  imc_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (out_valid && out_stall) begin
        skid_data  <= load_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= load_data;
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `IMC_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid holds item with empty output")
  `IMC_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall, out_valid && !skid_valid, "skid did not drain")
  `IMC_ASSERT_NEXT(a_no_load_when_full, clk, rst, skid_valid && out_stall, skid_valid && $stable(skid_data), "skid item overwritten")

endmodule

/* hdl/inactivity_mood_controller.sv */
// Top level of the inactivity mood controller.
`timescale 1ns / 1ps
`include "inactivity_mood_controller_macros.svh"

// One item is taken per clock if in_stall is low, its result registered; the
// whole decision (stillness subtract, three threshold compares, sleep check)
// sits between the input handshake and the output register. A two-entry
// result buffer lets the block keep taking items while one result waits;
// in_stall rises only when both entries are held. Write thresholds through
// cfg_we/cfg_index/cfg_data only while no item is in flight.
module inactivity_mood_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] now_ms,
  input  logic        screen_down,
  input  logic        moving,
  input  logic        user_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  level,
  output logic [6:0]  brightness,
  output logic        clock_shown,
  output logic        voice_ready,
  output logic        level_changed,
  output logic        sleep_due
);

  imc_pkg::cfg_t    cfg;
  imc_pkg::state_t  state;
  imc_pkg::state_t  state_next;
  imc_pkg::result_t result;
  imc_pkg::result_t out_data;
  logic             accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ambient_after_ms <= 32'd30000;
      cfg.whisper_after_ms <= 32'd120000;
      cfg.dream_after_ms   <= 32'd600000;
      cfg.sleep_delay_ms   <= 32'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        imc_pkg::REG_AMBIENT_AFTER: cfg.ambient_after_ms <= cfg_data;
        imc_pkg::REG_WHISPER_AFTER: cfg.whisper_after_ms <= cfg_data;
        imc_pkg::REG_DREAM_AFTER:   cfg.dream_after_ms   <= cfg_data;
        imc_pkg::REG_SLEEP_DELAY:   cfg.sleep_delay_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.level            <= imc_pkg::LVL_AWAKE;
      state.still_since      <= 32'd0;
      state.last_change_time <= 32'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  imc_eval u_eval (
    .state       (state),
    .cfg         (cfg),
    .cmd         (cmd),
    .now_ms      (now_ms),
    .screen_down (screen_down),
    .moving      (moving),
    .user_active (user_active),
    .state_next  (state_next),
    .result      (result)
  );

  imc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign level         = out_data.level;
  assign brightness    = out_data.brightness;
  assign clock_shown   = out_data.clock_shown;
  assign voice_ready   = out_data.voice_ready;
  assign level_changed = out_data.level_changed;
  assign sleep_due     = out_data.sleep_due;

  `IMC_ASSERT_NEXT(a_wake_cmd, clk, rst, accept && cmd, state.level == imc_pkg::LVL_AWAKE && state.still_since == $past(now_ms), "wake command did not reset level")
  `IMC_ASSERT_NOW(a_due_only_dream, clk, rst, out_valid && sleep_due, level == imc_pkg::LVL_DREAM && clock_shown && !voice_ready, "sleep due outside dream")
  `IMC_ASSERT_NEXT(a_state_holds, clk, rst, !accept, $stable(state), "state moved without an item")

endmodule
